FILE: sv/iol_pkg.sv
// ----------------------------------------------------------------------------
// iol_pkg
// Shared types and constants for the indexed ordered list: command and
// status codes, field widths and the control word broadcast to the cells.
// ----------------------------------------------------------------------------
package iol_pkg;

   localparam int DEFAULT_CAPACITY = 16;
   localparam int MAX_CAPACITY     = 256;

   localparam int CMD_W    = 2;
   localparam int POS_W    = 4;
   localparam int ITEM_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // wide enough for any list position or count up to MAX_CAPACITY
   localparam int TGT_W = $clog2(MAX_CAPACITY + 1);

   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_READ   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_DELETE = 2'd2
   } cell_op_type;

   typedef struct packed {
      cell_op_type        op;
      logic [TGT_W-1:0]   target;
   } cell_ctrl_type;

endpackage

FILE: sv/iol_if.sv
// ----------------------------------------------------------------------------
// iol_req_if / iol_rsp_if
// Valid/ready channels carrying command items in and result items out.
// ----------------------------------------------------------------------------
interface iol_req_if
   import iol_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [POS_W-1:0]  position;
   logic [ITEM_W-1:0] item;

   modport source (output valid, output command, output position, output item,
                   input ready);
   modport sink   (input valid, input command, input position, input item,
                   output ready);
endinterface

interface iol_rsp_if
   import iol_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ITEM_W-1:0]   read_item;
   logic [COUNT_W-1:0]  entry_count;

   modport source (output valid, output status, output read_item,
                   output entry_count, input ready);
   modport sink   (input valid, input status, input read_item,
                   input entry_count, output ready);
endinterface

FILE: sv/indexed_ordered_list.sv
// ----------------------------------------------------------------------------
// indexed_ordered_list
// Ordered list of up to CAPACITY item handles held in a row of cells.
// Append, insert, delete and read by position, one result item per command.
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake      | payload
//   --------+-----+----------------+-------------------------------------
//   req_if  | in  | valid / ready  | command, position, item
//   rsp_if  | out | valid / ready  | status, read_item, entry_count
//
// For each command, status is decided from the count register,
// every cell shifts in parallel at the same edge, and the result lands in
// the output register. Sustained rate is one item per cycle unless rsp_if stalls.
// req_if.ready is high outside reset whenever the output register is empty
// or being taken.
// Reset clears the count and the output valid; cell contents stay as they are.
// A stall on rsp_if holds the result and stops intake until it drains.
// ----------------------------------------------------------------------------
module indexed_ordered_list
   import iol_pkg::*;
   #(
   parameter int CAPACITY = DEFAULT_CAPACITY
   ) (
   input  logic      clock,
   input  logic      reset,
   iol_req_if.sink   req_if,
   iol_rsp_if.source rsp_if
   );

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [TGT_W-1:0] CAP_T = TGT_W'(CAPACITY);

   // count of entries held
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;

   // result register
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   status_type          status_ff;
   status_type          status_in;
   logic [ITEM_W-1:0]   read_item_ff;
   logic [ITEM_W-1:0]   read_item_in;
   logic [COUNT_W-1:0]  entry_count_ff;
   logic [COUNT_W-1:0]  entry_count_in;

   logic              accept;
   cmd_type           cmd;
   logic [TGT_W-1:0]  pos_t;
   logic [TGT_W-1:0]  cnt_t;
   logic [TGT_W-1:0]  cnt_new_t;
   logic              full;
   cell_ctrl_type     ctrl;
   logic [ITEM_W-1:0] read_mux;

   logic [ITEM_W-1:0] cell_data [CAPACITY];
   logic [ITEM_W-1:0] cell_rd   [CAPACITY];

   assign accept       = req_if.valid && req_if.ready;
   assign req_if.ready = !reset && (!rsp_valid_ff || rsp_if.ready);
   assign cmd          = cmd_type'(req_if.command);
   assign pos_t        = TGT_W'(req_if.position);
   assign cnt_t        = TGT_W'(cnt_ff);
   assign full         = (cnt_t == CAP_T);

   // decode the command into a status, a new count and the cell control word
   always_comb begin
      status_in   = ST_DONE;
      cnt_in      = cnt_ff;
      ctrl.op     = CELL_HOLD;
      ctrl.target = pos_t;
      unique case (cmd)
         CMD_APPEND: begin
            // append is an insert at the end of the list
            ctrl.target = cnt_t;
            if (full) begin
               status_in = ST_FULL;
            end else begin
               ctrl.op = CELL_INSERT;
               cnt_in  = cnt_ff + CNT_W'(1);
            end
         end
         CMD_INSERT: begin
            // position equal to count inserts at the end
            if (pos_t > cnt_t) begin
               status_in = ST_RANGE;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               ctrl.op = CELL_INSERT;
               cnt_in  = cnt_ff + CNT_W'(1);
            end
         end
         CMD_DELETE: begin
            if (pos_t >= cnt_t) begin
               status_in = ST_RANGE;
            end else begin
               ctrl.op = CELL_DELETE;
               cnt_in  = cnt_ff - CNT_W'(1);
            end
         end
         CMD_READ: begin
            if (pos_t >= cnt_t) begin
               status_in = ST_RANGE;
            end
         end
         default: begin
         end
      endcase
      // drop the update unless an item is actually taken
      if (!accept) begin
         ctrl.op = CELL_HOLD;
         cnt_in  = cnt_ff;
      end
   end

   // row of cells; the ends feed themselves back
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [ITEM_W-1:0] left_data;
      logic [ITEM_W-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = cell_data[i];
      end else begin : g_left
         assign left_data = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_data = cell_data[i];
      end else begin : g_right
         assign right_data = cell_data[i+1];
      end

      iol_cell #(
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .item       (req_if.item),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i]),
         .rd_data    (cell_rd[i])
      );
   end

   // only the addressed cell drives a nonzero read value
   always_comb begin
      read_mux = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_mux = read_mux | cell_rd[i];
      end
   end

   assign cnt_new_t = TGT_W'(cnt_in);

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      read_item_in   = read_item_ff;
      entry_count_in = entry_count_ff;
      if (accept) begin
         rsp_valid_in   = 1'b1;
         entry_count_in = cnt_new_t[COUNT_W-1:0];
         read_item_in   = (cmd == CMD_READ && status_in == ST_DONE) ? read_mux : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: hold unless a new item is taken
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
      end
      read_item_ff   <= read_item_in;
      entry_count_ff <= entry_count_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = status_ff;
   assign rsp_if.read_item   = read_item_ff;
   assign rsp_if.entry_count = entry_count_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_t <= CAP_T)
      else $error("entry count exceeds capacity");

   a_full_append_holds: assert property (@(posedge clock) disable iff (reset)
      accept && cmd == CMD_APPEND && full |=> $stable(cnt_ff))
      else $error("append into full list changed the count");

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item produced no result");

   a_fail_zero_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff != ST_DONE |-> read_item_ff == '0)
      else $error("failed command returned a nonzero read item");

   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> entry_count_ff == cnt_t[COUNT_W-1:0])
      else $error("result count differs from held count");

endmodule

FILE: sv/iol_cell.sv
// ----------------------------------------------------------------------------
// iol_cell
// One list slot. Takes the new item, its left neighbor's entry or its right
// neighbor's entry, or holds its own, depending on the broadcast control word.
// ----------------------------------------------------------------------------
module iol_cell
   import iol_pkg::*;
   #(
   parameter int INDEX = 0
   ) (
   input  logic              clock,
   input  cell_ctrl_type     ctrl,
   input  logic [ITEM_W-1:0] item,
   input  logic [ITEM_W-1:0] left_data,
   input  logic [ITEM_W-1:0] right_data,
   output logic [ITEM_W-1:0] data,
   output logic [ITEM_W-1:0] rd_data
   );

   localparam logic [TGT_W-1:0] IDX = TGT_W'(INDEX);

   logic [ITEM_W-1:0] data_ff;
   logic [ITEM_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (ctrl.op)
         CELL_INSERT: begin
            if (ctrl.target == IDX) begin
               data_in = item;
            end else if (ctrl.target < IDX) begin
               data_in = left_data;
            end
         end
         CELL_DELETE: begin
            // close the gap: pull from the right
            if (ctrl.target <= IDX) begin
               data_in = right_data;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data    = data_ff;
   assign rd_data = (ctrl.target == IDX) ? data_ff : '0;

endmodule
